[rtl/ata_pkg.sv]
// Package for the accelerometer tilt-angle block: widths, CORDIC angle table,
// lane control struct. No dependencies.
package ata_pkg;
  localparam int CordicStages = 16;
  localparam int AngleFracBits = 8;
  localparam int AccFrac = 16;
  localparam int SqW = 50;               // sum of squares shifted by 16
  localparam int MagW = 25;              // magnitudes with 8 fraction bits
  localparam int CW = MagW + 3;          // CORDIC x/y width
  localparam int ZW = 25;                // accumulator width
  localparam int RootSteps = SqW / 2;    // one root bit per stage
  localparam logic [ZW-1:0] NinetyAcc = 25'd5898240;
  localparam int StageCount = RootSteps + CordicStages + 2;

  typedef struct packed {
    logic neg;
    logic num_zero;
    logic den_zero;
  } lane_ctl_t;

  function automatic logic [ZW-1:0] atan_tab(input int i);
    logic [ZW-1:0] t;
    case (i)
      0: t = 25'd2949120;  1: t = 25'd1740967;  2: t = 25'd919879;
      3: t = 25'd466945;   4: t = 25'd234379;   5: t = 25'd117304;
      6: t = 25'd58666;    7: t = 25'd29335;    8: t = 25'd14668;
      9: t = 25'd7334;     10: t = 25'd3667;    11: t = 25'd1833;
      12: t = 25'd917;     13: t = 25'd458;     14: t = 25'd229;
      15: t = 25'd115;     16: t = 25'd57;      17: t = 25'd29;
      18: t = 25'd14;      19: t = 25'd7;       20: t = 25'd4;
      21: t = 25'd2;       22: t = 25'd1;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage

[rtl/ata_if.sv]
// Valid/ready channel interfaces for the tilt-angle block.
// Depends on nothing.
interface ata_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source(output valid, accel_x, accel_y, accel_z, input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface ata_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] tilt_angle;
  logic [2:0] undefined_mask;
  modport source(output valid, roll_angle, pitch_angle, tilt_angle, undefined_mask,
                 input ready);
  modport sink(input valid, roll_angle, pitch_angle, tilt_angle, undefined_mask,
               output ready);
endinterface

[rtl/ata_lane.sv]
// One angle lane: pipelined square root, then pipelined vectoring CORDIC and rounding.
// Depends on ata_pkg.
module ata_lane
  import ata_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [SqW-1:0]       sq,       // sum of squares << 16 (root operand)
  input  logic [MagW-1:0]      plain,    // |axis| << 8
  input  logic                 root_is_num,
  input  logic                 neg,
  output logic signed [15:0]   angle,
  output logic                 undef
);
  // Square root stages: restoring, one result bit per stage.
  logic [SqW-1:0]  rrem [RootSteps+1];
  logic [MagW-1:0] rres [RootSteps+1];
  logic [MagW-1:0] rplain [RootSteps+1];
  logic            rnum [RootSteps+1];
  logic            rneg [RootSteps+1];

  always_comb begin
    rrem[0] = sq; rres[0] = '0; rplain[0] = plain; rnum[0] = root_is_num; rneg[0] = neg;
  end

  for (genvar i = 0; i < RootSteps; i++) begin : g_root
    localparam int Sh = 2 * (RootSteps - 1 - i);
    logic [SqW+1:0] trial;
    logic [SqW+1:0] rem_hi;
    always_comb begin
      trial = ({2'b0, rres[i], 2'b01}) << Sh;
      rem_hi = {2'b0, rrem[i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_hi >= trial) begin
          rrem[i+1] <= SqW'(rem_hi - trial);
          rres[i+1] <= {rres[i][MagW-2:0], 1'b1};
        end else begin
          rrem[i+1] <= rrem[i];
          rres[i+1] <= {rres[i][MagW-2:0], 1'b0};
        end
        rplain[i+1] <= rplain[i];
        rnum[i+1] <= rnum[i];
        rneg[i+1] <= rneg[i];
      end
    end
  end

  // CORDIC stages.
  logic signed [CW-1:0] cx [CordicStages+1];
  logic signed [CW-1:0] cy [CordicStages+1];
  logic signed [ZW:0]   cz [CordicStages+1];
  lane_ctl_t            cc [CordicStages+1];
  logic [MagW-1:0] num0, den0;

  always_comb begin
    num0 = rnum[RootSteps] ? rres[RootSteps] : rplain[RootSteps];
    den0 = rnum[RootSteps] ? rplain[RootSteps] : rres[RootSteps];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= CW'(den0);
      cy[0] <= CW'(num0);
      cz[0] <= '0;
      cc[0] <= '{neg: rneg[RootSteps], num_zero: num0 == '0, den_zero: den0 == '0};
    end
  end

  for (genvar i = 0; i < CordicStages; i++) begin : g_cordic
    localparam logic [ZW-1:0] Ang = atan_tab(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[i] >= 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + $signed({1'b0, Ang});
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - $signed({1'b0, Ang});
        end
        cc[i+1] <= cc[i];
      end
    end
  end

  // Special cases, clamp, round and sign.
  localparam int S = AccFrac - AngleFracBits;
  localparam logic [ZW:0] Lim = (ZW+1)'(90) << AngleFracBits;
  logic signed [ZW:0] acc;
  logic [ZW:0]        r;
  logic signed [ZW+1:0] sr;
  lane_ctl_t          c;
  always_comb begin
    c = cc[CordicStages];
    if (c.num_zero) acc = '0;
    else if (c.den_zero) acc = $signed({1'b0, NinetyAcc});
    else acc = cz[CordicStages];
    if (acc < 0) acc = '0;
    if (acc > $signed({1'b0, NinetyAcc})) acc = $signed({1'b0, NinetyAcc});
    r = (ZW+1)'(($unsigned(acc) + ((ZW+1)'(1) << (S - 1))) >> S);
    if (r > Lim) r = Lim;
    sr = c.neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (sr > 32767) sr = 32767;
    if (sr < -32768) sr = -32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= 16'(sr);
      undef <= c.num_zero && c.den_zero;
    end
  end
endmodule

[rtl/ata_merge.sv]
// Merging stage: packs the three lane results into one output transfer and
// holds it in a skid pair so the pipeline can run while the sink stalls, until the skid fills.
// Depends on ata_pkg and ata_if.
module ata_merge
  import ata_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] roll,
  input  logic signed [15:0] pitch,
  input  logic signed [15:0] tilt,
  input  logic [2:0]         mask,
  ata_out_if.source          out
);
  logic [50:0] main_d, skid_d;
  logic        main_v, skid_v;

  assign in_ready = !skid_v;
  assign out.valid = main_v;
  assign {out.roll_angle, out.pitch_angle, out.tilt_angle, out.undefined_mask} = main_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (!main_v || out.ready) begin
        if (skid_v) begin
          main_d <= skid_d; main_v <= 1'b1; skid_v <= 1'b0;
        end else begin
          main_d <= {roll, pitch, tilt, mask}; main_v <= in_valid;
        end
      end else if (in_valid && !skid_v) begin
        skid_d <= {roll, pitch, tilt, mask}; skid_v <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst) skid_v |-> main_v)
    else $error("skid holds data while output register is empty");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    main_v && !out.ready |=> main_v && $stable(main_d))
    else $error("stalled result changed");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    skid_v && out.ready |=> main_v && !skid_v)
    else $error("skid entry not moved forward");
`endif
endmodule

[rtl/accel_tilt_angles_top.sv]
// Top level of the accelerometer tilt-angle block: squares, three angle lanes,
// merging stage. Depends on ata_pkg, ata_if, ata_lane and ata_merge.
//
//  channel  dir  fields
//  in       in   accel_x, accel_y, accel_z (signed 16)
//  out      out  roll_angle, pitch_angle, tilt_angle (signed 16), undefined_mask (3)
//
// One sample is accepted per cycle while the output keeps up. A result passes through
// these registers after its input transfer: the squaring register is loaded at the
// transfer edge, then 25 square-root stages, the CORDIC load register, 16 CORDIC stages,
// the rounding register and the output register follow. The square-root pipeline, one
// result bit per stage, sets the depth.
// Reset is synchronous and clears only valid bits. When the output stalls, the skid
// register takes the transfer leaving the lanes and the whole pipeline then freezes;
// input ready stays low until the skid entry has moved to the output register.
module accel_tilt_angles_top
  import ata_pkg::*;
(
  input logic      clk,
  input logic      rst,
  ata_in_if.sink   in,
  ata_out_if.source out
);
  // The pipeline advances whenever the merging stage can take its product.
  logic en, m_ready;
  logic [StageCount:0] vld;
  assign en = m_ready;
  assign in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[StageCount-1:0], in.valid};
  end

  // Squares and absolute values, registered.
  logic [31:0] xx, yy, zz;
  logic [MagW-1:0] ax, ay, az;
  logic sx_pos, sy_neg, sz_neg;
  always_ff @(posedge clk) begin
    if (en) begin
      xx <= 32'(in.accel_x * in.accel_x);
      yy <= 32'(in.accel_y * in.accel_y);
      zz <= 32'(in.accel_z * in.accel_z);
      ax <= {1'b0, (in.accel_x < 0) ? 16'(-in.accel_x) : 16'(in.accel_x), 8'd0};
      ay <= {1'b0, (in.accel_y < 0) ? 16'(-in.accel_y) : 16'(in.accel_y), 8'd0};
      az <= {1'b0, (in.accel_z < 0) ? 16'(-in.accel_z) : 16'(in.accel_z), 8'd0};
      sx_pos <= in.accel_x > 0;
      sy_neg <= in.accel_y < 0;
      sz_neg <= in.accel_z < 0;
    end
  end

  logic [SqW-1:0] s_xz, s_yz, s_xy;
  assign s_xz = {(SqW-16)'({1'b0, xx} + {1'b0, zz}), 16'd0};
  assign s_yz = {(SqW-16)'({1'b0, yy} + {1'b0, zz}), 16'd0};
  assign s_xy = {(SqW-16)'({1'b0, xx} + {1'b0, yy}), 16'd0};

  logic signed [15:0] roll, pitch, tilt;
  logic [2:0] mask;

  // Roll: |y| over the root of x and z.
  ata_lane u_roll (.clk, .en, .sq(s_xz), .plain(ay), .root_is_num(1'b0),
    .neg(sy_neg), .angle(roll), .undef(mask[0]));
  // Pitch: |x| over the root of y and z, negated for positive x.
  ata_lane u_pitch (.clk, .en, .sq(s_yz), .plain(ax), .root_is_num(1'b0),
    .neg(sx_pos), .angle(pitch), .undef(mask[1]));
  // Tilt: root of x and y over |z|, sign follows z.
  ata_lane u_tilt (.clk, .en, .sq(s_xy), .plain(az), .root_is_num(1'b1),
    .neg(sz_neg), .angle(tilt), .undef(mask[2]));

  ata_merge u_merge (.clk, .rst, .in_valid(vld[StageCount] && en), .in_ready(m_ready),
    .roll, .pitch, .tilt, .mask, .out);

`ifndef SYNTHESIS
  a_freeze: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("pipeline moved while stalled");
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in.valid && in.ready |=> vld[0])
    else $error("accepted sample lost at entry");
  a_ready_skid: assert property (@(posedge clk) disable iff (rst)
    !in.ready |-> out.valid)
    else $error("input stalled with no result waiting");
`endif
endmodule

[sim/tb_accel_tilt_angles_top.sv]
// Testbench for accel_tilt_angles_top: directed table of samples, then random samples,
// every result checked in order against typed-in values or a behavioral tilt-angle predictor.
// Depends on ata_pkg, ata_if and the RTL of the block.
module tb_accel_tilt_angles_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ata_pkg::*;

  localparam int TblLen = 20;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] tilt;
    logic [2:0] undef_bits;
  } angles_t;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    bit known;
    angles_t want;
  } sample_row_t;

  logic clk;
  logic rst;
  int cycle_cnt;
  int err_cnt;
  angles_t pending_angles[$];

  ata_in_if in_ch();
  ata_out_if out_ch();

  accel_tilt_angles_top dut (
    .clk(clk),
    .rst(rst),
    .in(in_ch.sink),
    .out(out_ch.source)
  );

  // Free-running clock with a 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Floor square root of a nonnegative 64-bit value, one result bit per pass.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC: atan(num/den) in degrees with 16 fraction bits.
  // The arithmetic shift of a longint floors, as the hardware does.
  function automatic longint cordic_degrees(input longint num, input longint den);
    longint cx, cy, cz, xs, ys;
    cx = den;
    cy = num;
    cz = 0;
    for (int i = 0; i < CordicStages; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy >= 0) begin
        cx += ys; cy -= xs; cz += longint'(atan_tab(i));
      end else begin
        cx -= ys; cy += xs; cz -= longint'(atan_tab(i));
      end
    end
    return cz;
  endfunction

  // One angle from magnitudes; reports zero over zero through undef.
  function automatic logic signed [15:0] lane_angle(input longint num, input longint den,
                                                    input bit neg, output bit undef);
    longint acc, r, lim;
    int s;
    s = AccFrac - AngleFracBits;
    undef = 1'b0;
    if (num == 0 && den == 0) begin
      undef = 1'b1;
      return '0;
    end
    if (num == 0) acc = 0;
    else if (den == 0) acc = longint'(NinetyAcc);
    else acc = cordic_degrees(num, den);
    if (acc < 0) acc = 0;
    if (acc > longint'(NinetyAcc)) acc = longint'(NinetyAcc);
    r = (acc + (longint'(1) << (s - 1))) >>> s;
    lim = longint'(90) << AngleFracBits;
    if (r > lim) r = lim;
    if (neg) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic angles_t predict_angles(input logic signed [15:0] sx,
                                             input logic signed [15:0] sy,
                                             input logic signed [15:0] sz);
    longint x, y, z, xx, yy, zz, m_xz, m_yz, m_xy;
    bit u0, u1, u2;
    angles_t a;
    x = sx; y = sy; z = sz;
    xx = x * x; yy = y * y; zz = z * z;
    m_xz = longint'(floor_sqrt(longint'(xx + zz) << 16));
    m_yz = longint'(floor_sqrt(longint'(yy + zz) << 16));
    m_xy = longint'(floor_sqrt(longint'(xx + yy) << 16));
    a.roll = lane_angle((y < 0 ? -y : y) * 256, m_xz, y < 0, u0);
    a.pitch = lane_angle((x < 0 ? -x : x) * 256, m_yz, x > 0, u1);
    a.tilt = lane_angle(m_xy, (z < 0 ? -z : z) * 256, z < 0, u2);
    a.undef_bits = {u2, u1, u0};
    return a;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int idle_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random axis value, biased toward zero, small values and the extremes.
  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 9))
      0: return 16'sd0;
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2, 3: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  sample_row_t sample_tbl[TblLen];

  // Directed rows. Results are typed in only for the cases that are obvious:
  // all zero (zero over zero), a lone axis (angles of zero or exactly 90 degrees).
  initial begin
    sample_tbl[0] = '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 3'b111}};
    sample_tbl[1] = '{16'sd0, 16'sd0, 16'sd1, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 3'b000}};
    sample_tbl[2] = '{16'sd0, 16'sd0, -16'sd1, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 3'b000}};
    sample_tbl[3] = '{16'sd0, 16'sh7fff, 16'sd0, 1'b1,
                      '{16'sd23040, 16'sd0, 16'sd23040, 3'b000}};
    sample_tbl[4] = '{16'sd0, 16'sh8000, 16'sd0, 1'b1,
                      '{-16'sd23040, 16'sd0, 16'sd23040, 3'b000}};
    sample_tbl[5] = '{16'sh7fff, 16'sd0, 16'sd0, 1'b1,
                      '{16'sd0, -16'sd23040, 16'sd23040, 3'b000}};
    sample_tbl[6] = '{16'sh8000, 16'sd0, 16'sd0, 1'b1,
                      '{16'sd0, 16'sd23040, 16'sd23040, 3'b000}};
    sample_tbl[7] = '{16'sd0, 16'sd0, 16'sh8000, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 3'b000}};
    sample_tbl[8] = '{16'sd0, 16'sd0, 16'sh7fff, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 3'b000}};
    sample_tbl[9] = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '0};
    sample_tbl[10] = '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0};
    sample_tbl[11] = '{16'sh8000, 16'sh7fff, -16'sd1, 1'b0, '0};
    sample_tbl[12] = '{16'sd1, 16'sd1, 16'sd1, 1'b0, '0};
    sample_tbl[13] = '{-16'sd1, -16'sd1, -16'sd1, 1'b0, '0};
    sample_tbl[14] = '{16'sd100, -16'sd200, 16'sd16384, 1'b0, '0};
    sample_tbl[15] = '{16'sd1, 16'sd0, 16'sh7fff, 1'b0, '0};
    sample_tbl[16] = '{16'sh7fff, 16'sd1, 16'sd0, 1'b0, '0};
    sample_tbl[17] = '{-16'sd16384, 16'sd16384, -16'sd16384, 1'b0, '0};
    sample_tbl[18] = '{16'sh5555, 16'shaaaa, 16'sh0f0f, 1'b0, '0};
    sample_tbl[19] = '{16'sd3, -16'sd4, 16'sd0, 1'b0, '0};
  end

  // Drive one sample and hold it until the transfer completes. Called at a
  // falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input logic signed [15:0] sx, input logic signed [15:0] sy,
                             input logic signed [15:0] sz, input bit known,
                             input angles_t want);
    in_ch.valid <= 1'b1;
    in_ch.accel_x <= sx;
    in_ch.accel_y <= sy;
    in_ch.accel_z <= sz;
    do @(posedge clk); while (!in_ch.ready);
    // Queue the expectation at the edge of the transfer, before the output
    // side can possibly see the matching result.
    pending_angles.push_back(known ? want : predict_angles(sx, sy, sz));
    @(negedge clk);
  endtask

  // Stimulus. Valid is only dropped when a gap follows, so it never toggles
  // twice in one step.
  initial begin
    int gap;
    logic signed [15:0] rx, ry, rz;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.accel_x = '0;
    in_ch.accel_y = '0;
    in_ch.accel_z = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (sample_tbl[i]) begin
      send_sample(sample_tbl[i].ax, sample_tbl[i].ay, sample_tbl[i].az,
                  sample_tbl[i].known, sample_tbl[i].want);
      gap = (i < 10) ? 0 : idle_gap();
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    for (int n = 0; n < 750; n++) begin
      rx = rand_axis();
      ry = rand_axis();
      rz = rand_axis();
      send_sample(rx, ry, rz, 1'b0, '0);
      // Stretches of back-to-back transfers in the middle of the run.
      gap = (n >= 300 && n < 400) ? 0 : idle_gap();
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b0;
    wait (pending_angles.size() == 0);
    repeat (StageCount + 10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("accel_tilt_angles_top: match");
    end else begin
      $display("accel_tilt_angles_top: mismatch");
    end
    $finish;
  end

  // Result side: ready idles at random, also in stretches, changing only at
  // the falling edge.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        hold = idle_gap();
        out_ch.ready <= (hold == 0) || (cycle_cnt % 2000 < 400);
        if (hold == 0) hold = $urandom_range(0, 6);
      end
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    angles_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_angles.size() == 0) begin
        $display("%0t: result with nothing expected: roll %0d pitch %0d tilt %0d mask %b",
                 $time, out_ch.roll_angle, out_ch.pitch_angle, out_ch.tilt_angle,
                 out_ch.undefined_mask);
        err_cnt++;
      end else begin
        want = pending_angles.pop_front();
        if (out_ch.roll_angle !== want.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, want.roll, out_ch.roll_angle);
          err_cnt++;
        end
        if (out_ch.pitch_angle !== want.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                   out_ch.pitch_angle);
          err_cnt++;
        end
        if (out_ch.tilt_angle !== want.tilt) begin
          $display("%0t: tilt expected %0d actual %0d", $time, want.tilt, out_ch.tilt_angle);
          err_cnt++;
        end
        if (out_ch.undefined_mask !== want.undef_bits) begin
          $display("%0t: mask expected %b actual %b", $time, want.undef_bits,
                   out_ch.undefined_mask);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("accel_tilt_angles_top: mismatch");
      $finish;
    end
  end

  initial begin
    cycle_cnt = 0;
    err_cnt = 0;
  end
endmodule
